// ----- hdl/sat_pkg.sv -----
// ----------------------------------------------------------------------------
// sat_pkg
// Types, codes and defaults shared by the sorted key table modules.
// ----------------------------------------------------------------------------
package sat_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes (code 3 is unused: it changes nothing and returns a zero value with OK status)
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key;
        logic [POS_W-1:0]    position;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_LK_CAP,
        S_DEL_CAP,
        S_DEL_SH,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_CNT,
        IDX_LOAD_POS,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [2:0] {
        RA_POS,
        RA_IDX_M1,
        RA_IDX_M2,
        RA_IDX_P1,
        RA_IDX_P2
    } t_rd_addr;

    typedef enum logic [1:0] {
        VAL_HOLD,
        VAL_ZERO,
        VAL_RDATA
    } t_val_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Controller to datapath
    typedef struct packed {
        logic                load_in;
        t_idx_op             idx_op;
        t_rd_addr            rd_addr;
        logic                wr_en;
        logic                wr_key;
        t_val_op             val_op;
        t_cnt_op             cnt_op;
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                full;
        logic                range;
        logic                cnt_zero;
        logic                idx_one;
        logic                rd_ge_key;
        logic                more1;
        logic                more2;
        logic                out_free;
    } t_dp_sts;

endpackage

// ----- hdl/sat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer for insert, lookup and delete over the key memory.
// ----------------------------------------------------------------------------
module sat_ctrl
    import sat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.idx_op   = IDX_HOLD;
        o_cmd.rd_addr  = RA_POS;
        o_cmd.val_op   = VAL_HOLD;
        o_cmd.cnt_op   = CNT_HOLD;
        o_cmd.st_code  = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end

            // Item registers valid; read at position is issued here
            S_DECODE: begin
                o_cmd.rd_addr = RA_POS;
                o_cmd.st_load = 1'b1;
                unique case (i_sts.opcode)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.val_op  = VAL_ZERO;
                            o_cmd.st_code = ST_FULL;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.idx_op  = IDX_LOAD_CNT;
                            o_cmd.st_code = ST_OK;
                            n_state       = i_sts.cnt_zero ? S_INS_PUT : S_INS_RD;
                        end
                    end
                    OP_LOOKUP: begin
                        if (i_sts.range) begin
                            o_cmd.val_op  = VAL_ZERO;
                            o_cmd.st_code = ST_RANGE;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.st_code = ST_OK;
                            n_state       = S_LK_CAP;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.range) begin
                            o_cmd.val_op  = VAL_ZERO;
                            o_cmd.st_code = ST_RANGE;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.idx_op  = IDX_LOAD_POS;
                            o_cmd.st_code = ST_OK;
                            n_state       = S_DEL_CAP;
                        end
                    end
                    default: begin
                        o_cmd.val_op  = VAL_ZERO;
                        o_cmd.st_code = ST_OK;
                        n_state       = S_DONE;
                    end
                endcase
            end

            S_INS_RD: begin
                o_cmd.rd_addr = RA_IDX_M1;
                n_state       = S_INS_CMP;
            end

            // Walk down from the top: shift up while the entry is not less than key
            S_INS_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.rd_ge_key) begin
                    o_cmd.wr_key  = 1'b0;
                    o_cmd.idx_op  = IDX_DEC;
                    o_cmd.rd_addr = RA_IDX_M2;
                    if (i_sts.idx_one) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    o_cmd.wr_key = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.val_op = VAL_ZERO;
                    n_state      = S_DONE;
                end
            end

            S_INS_PUT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_key = 1'b1;
                o_cmd.cnt_op = CNT_INC;
                o_cmd.val_op = VAL_ZERO;
                n_state      = S_DONE;
            end

            S_LK_CAP: begin
                o_cmd.val_op = VAL_RDATA;
                n_state      = S_DONE;
            end

            // Keep the removed key, then pull later entries down
            S_DEL_CAP: begin
                o_cmd.val_op = VAL_RDATA;
                if (i_sts.more1) begin
                    o_cmd.rd_addr = RA_IDX_P1;
                    n_state       = S_DEL_SH;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_DONE;
                end
            end

            S_DEL_SH: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_key = 1'b0;
                o_cmd.idx_op = IDX_INC;
                if (i_sts.more2) begin
                    o_cmd.rd_addr = RA_IDX_P2;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_DONE;
                end
            end

            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/sat_dp.sv -----
// ----------------------------------------------------------------------------
// sat_dp
// Key memory, index and count registers, capacity register and result register.
// ----------------------------------------------------------------------------
module sat_dp
    import sat_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    logic [OPCODE_W-1:0]  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [POS_W-1:0]     r_pos;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        n_cnt;
    logic [CAP_W-1:0]     r_cap;
    logic [KEY_WIDTH-1:0] r_rdata;
    logic [KEY_WIDTH-1:0] r_value;
    logic [STATUS_W-1:0]  r_st;
    logic                 r_ov;
    t_out_item            r_out;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] wr_data;

    // Item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in_item.opcode;
            r_key <= KEY_WIDTH'(i_in_item.key);
            r_pos <= i_in_item.position;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Walking index
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.idx_op)
            IDX_LOAD_CNT: r_idx <= r_cnt;
            IDX_LOAD_POS: r_idx <= CW'(r_pos);
            IDX_DEC:      r_idx <= r_idx - CW'(1);
            IDX_INC:      r_idx <= r_idx + CW'(1);
            default:      r_idx <= r_idx;
        endcase
    end

    // Stored count
    always_comb begin
        unique case (i_cmd.cnt_op)
            CNT_INC: n_cnt = r_cnt + CW'(1);
            CNT_DEC: n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Read address select
    always_comb begin
        unique case (i_cmd.rd_addr)
            RA_IDX_M1: rd_addr = AW'(r_idx - CW'(1));
            RA_IDX_M2: rd_addr = AW'(r_idx - CW'(2));
            RA_IDX_P1: rd_addr = AW'(r_idx + CW'(1));
            RA_IDX_P2: rd_addr = AW'(r_idx + CW'(2));
            default:   rd_addr = AW'(r_pos);
        endcase
    end

    assign wr_data = i_cmd.wr_key ? r_key : r_rdata;

    // Key memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[AW'(r_idx)] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Result value and status
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.val_op)
            VAL_ZERO:  r_value <= '0;
            VAL_RDATA: r_value <= r_rdata;
            default:   r_value <= r_value;
        endcase
        if (i_cmd.st_load) begin
            r_st <= i_cmd.st_code;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.value  <= VALUE_W'(r_value);
            r_out.status <= r_st;
            r_out.count  <= COUNT_W'(r_cnt);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // Status towards the controller
    always_comb begin
        o_sts.opcode    = r_op;
        o_sts.full      = (32'(r_cnt) >= 32'(r_cap)) || (32'(r_cnt) >= 32'(DEPTH));
        o_sts.range     = 32'(r_pos) >= 32'(r_cnt);
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.idx_one   = (r_idx == CW'(1));
        o_sts.rd_ge_key = !(r_rdata < r_key);
        o_sts.more1     = ({1'b0, r_idx} + (CW+1)'(1)) < {1'b0, r_cnt};
        o_sts.more2     = ({1'b0, r_idx} + (CW+1)'(2)) < {1'b0, r_cnt};
        o_sts.out_free  = !r_ov || i_out_ready;
    end

endmodule

// ----- hdl/sorted_array_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_array_table_top
// Sorted key table: insert in order, lookup by index, delete by index.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready    | i_in_item  (opcode, key, position)
//  result   | o_out_valid / i_out_ready  | o_out_item (value, status, count)
//  config   | i_cfg_we                   | i_cfg_wdata (capacity)
//
//  One item at a time. Insert shifts the larger keys up from the top and then
//  writes the new key, delete returns the removed key and pulls later entries
//  down, lookup returns the key at the given index. One entry moves per cycle
//  through a key memory with one write and one registered read port. Reset
//  clears the count and sets capacity to 64, not the memory. A waiting result
//  lets one more item in, which then holds in its final state until the output
//  register is free.
// ----------------------------------------------------------------------------
module sorted_array_table_top
    import sat_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    sat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage and arithmetic
    sat_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Only one item in flight: busy right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while previous one still in progress");

    // Finishing an item returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result issued without the sequencer going idle");

    // A rejected operation returns a zero value
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_FULL || o_out_item.status == ST_RANGE)
        |-> o_out_item.value == '0)
        else $error("rejected operation returned a non-zero value");

endmodule
